// ===== sv/backward_lzss_decompressor_macros.svh =====
// Assertion macros shared by the backward LZSS decompressor modules.
`ifndef BACKWARD_LZSS_DECOMPRESSOR_MACROS_SVH
`define BACKWARD_LZSS_DECOMPRESSOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BLZD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BLZD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/blzd_pkg.sv =====
// Shared constants, codes and controller/datapath interface types of the decompressor.
package blzd_pkg;

    localparam int POS_W            = 24;
    localparam int BYTE_W           = 8;
    localparam int CFG_IDX_W        = 2;
    localparam int LEN_W            = 5;
    localparam int OFF_W            = 13;
    localparam int FLAGS_LEFT_W     = 4;
    localparam int FLAG_COUNT       = 8;
    localparam int LEN_BASE         = 3;
    localparam int OFF_BASE         = 2;
    localparam int PAIR_MIN_POS     = 2;
    localparam int WINDOW_DEPTH_DEF = 8192;
    localparam int TDATA_W          = 32;
    localparam int TUSER_W          = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE  = 2'd2;

    typedef enum logic [2:0] {
        OUT_NONE,
        OUT_COPY,
        OUT_PEND,
        OUT_DONE,
        OUT_ERR
    } t_out_sel;

    typedef struct packed {
        logic     capture;
        logic     op_ctrl;
        logic     op_lit;
        logic     op_high;
        logic     op_low;
        logic     rd_issue;
        logic     copy_wr;
        logic     settle_clear;
        t_out_sel push;
        logic     push_done;
    } t_dp_cmd;

    typedef struct packed {
        logic restart;
        logic out_free;
        logic rp_le_stop;
        logic rp_lt2;
        logic wp_zero;
        logic fl_zero;
        logic flag_msb;
        logic low_fail;
        logic cnt_last;
    } t_dp_status;

endpackage

// ===== sv/backward_lzss_decompressor.sv =====
// Top level of the backward LZSS decompressor: stream ports, configuration and glue.
//
// Usage: write start_position (index 0), stop_position (index 1) and
// output_size (index 2) through i_cfg_we/i_cfg_idx/i_cfg_data while the block
// is idle; each such write restarts the stream. Then send compressed bytes on
// the s_axis channel in descending address order. Each decoded byte leaves on
// m_axis with its buffer position, in descending position order; tlast marks
// the final result of the stream and tuser[1] an error result.
// A literal or control byte passes the execute and settle states, and a pair's
// high byte the execute state (the wait state too if it fails), before the next
// transfer is taken. The low byte of a pair starts a copy of L = 3..18 bytes,
// one byte per cycle while the output register is free, through the history
// read port (registered read); no input is taken meanwhile. Results load from
// the execute state for a done or error found at once, from the settle state
// for a literal or the end after a control byte, and from the copy-write state
// for a copy's first byte. A single output register decouples the two sides;
// while the receiver holds tready low, a result waiting to load pauses decoding
// and keeps s_axis_tready low. Reset clears the settings and stream state to
// zero, so the first item ends the stream at once. History needs no clearing.
module backward_lzss_decompressor #(
    parameter int WINDOW_DEPTH = blzd_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [blzd_pkg::BYTE_W-1:0]        s_axis_tdata,   // [7:0] in_byte
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [blzd_pkg::TDATA_W-1:0]       m_axis_tdata,   // [7:0] out_byte, [31:8] out_position
    output logic [blzd_pkg::TUSER_W-1:0]       m_axis_tuser,   // [0] byte_valid, [1] error
    output logic                               m_axis_tlast,
    input  logic                               i_cfg_we,
    input  logic [blzd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [blzd_pkg::POS_W-1:0]         i_cfg_data
);

    blzd_pkg::t_dp_cmd    w_cmd;
    blzd_pkg::t_dp_status w_status;
    logic [blzd_pkg::BYTE_W-1:0] w_out_byte;
    logic [blzd_pkg::POS_W-1:0]  w_out_pos;
    logic                        w_out_bvalid;
    logic                        w_out_err;

    blzd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready)
    );

    blzd_datapath #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_in_byte    (s_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_byte   (w_out_byte),
        .o_out_pos    (w_out_pos),
        .o_out_bvalid (w_out_bvalid),
        .o_out_done   (m_axis_tlast),
        .o_out_err    (w_out_err)
    );

    assign m_axis_tdata = {w_out_pos, w_out_byte};
    assign m_axis_tuser = {w_out_err, w_out_bvalid};

endmodule

// ===== sv/blzd_ctrl.sv =====
// Decoding sequencer: stream phase, step sequencing and result ordering.
`include "backward_lzss_decompressor_macros.svh"

module blzd_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  blzd_pkg::t_dp_status i_status,
    output blzd_pkg::t_dp_cmd    o_cmd,
    input  logic                 i_in_valid,
    output logic                 o_in_ready
);

    typedef enum logic [2:0] {
        S_WAIT,
        S_EXEC,
        S_CRD,
        S_CWR,
        S_SETTLE
    } t_state;

    typedef enum logic [1:0] {
        PH_CONTROL,
        PH_LITERAL,
        PH_HIGH,
        PH_LOW
    } t_phase;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic   r_finished, n_finished;
    logic   r_has_pend, n_has_pend;
    logic   w_cont;
    logic   w_end;

    // Another flag of the current control byte can be decoded.
    assign w_cont = !i_status.fl_zero && !i_status.rp_le_stop && !i_status.wp_zero;
    assign w_end  = !w_cont && i_status.rp_le_stop;

    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_finished = r_finished;
        n_has_pend = r_has_pend;
        o_cmd      = '0;
        o_cmd.push = blzd_pkg::OUT_NONE;
        o_in_ready = 1'b0;

        unique case (r_state)
            S_WAIT: begin
                o_in_ready = 1'b1;
            end
            S_EXEC: begin
                if (r_finished) begin
                    o_in_ready = 1'b1;
                    n_state    = S_WAIT;
                end else begin
                    unique case (r_phase)
                        PH_CONTROL: begin
                            if (i_status.rp_le_stop) begin
                                if (i_status.out_free) begin
                                    o_cmd.push = blzd_pkg::OUT_DONE;
                                    n_finished = 1'b1;
                                    n_state    = S_WAIT;
                                end
                            end else begin
                                o_cmd.op_ctrl = 1'b1;
                                n_state       = S_SETTLE;
                            end
                        end
                        PH_LITERAL: begin
                            o_cmd.op_lit = 1'b1;
                            n_has_pend   = 1'b1;
                            n_state      = S_SETTLE;
                        end
                        PH_HIGH: begin
                            if (i_status.rp_lt2) begin
                                if (i_status.out_free) begin
                                    o_cmd.push = blzd_pkg::OUT_ERR;
                                    n_finished = 1'b1;
                                    n_state    = S_WAIT;
                                end
                            end else begin
                                o_cmd.op_high = 1'b1;
                                n_phase       = PH_LOW;
                                o_in_ready    = 1'b1;
                                n_state       = S_WAIT;
                            end
                        end
                        PH_LOW: begin
                            if (i_status.low_fail) begin
                                if (i_status.out_free) begin
                                    o_cmd.push = blzd_pkg::OUT_ERR;
                                    n_finished = 1'b1;
                                    n_state    = S_WAIT;
                                end
                            end else begin
                                o_cmd.op_low = 1'b1;
                                n_state      = S_CRD;
                            end
                        end
                        default: begin
                            n_phase = PH_CONTROL;
                        end
                    endcase
                end
            end
            S_CRD: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_CWR;
            end
            S_CWR: begin
                // The last copied byte waits in the pending register until the
                // end-of-stream decision is known.
                if (i_status.cnt_last) begin
                    o_cmd.copy_wr = 1'b1;
                    n_has_pend    = 1'b1;
                    n_state       = S_SETTLE;
                end else if (i_status.out_free) begin
                    o_cmd.copy_wr  = 1'b1;
                    o_cmd.push     = blzd_pkg::OUT_COPY;
                    o_cmd.rd_issue = 1'b1;
                end
            end
            S_SETTLE: begin
                if (!((r_has_pend || w_end) && !i_status.out_free)) begin
                    if (w_cont) begin
                        n_phase = i_status.flag_msb ? PH_HIGH : PH_LITERAL;
                    end else begin
                        o_cmd.settle_clear = 1'b1;
                        n_phase            = PH_CONTROL;
                    end
                    if (w_end) begin
                        n_finished = 1'b1;
                    end
                    if (r_has_pend) begin
                        o_cmd.push      = blzd_pkg::OUT_PEND;
                        o_cmd.push_done = w_end;
                    end else if (w_end) begin
                        o_cmd.push = blzd_pkg::OUT_DONE;
                    end
                    n_has_pend = 1'b0;
                    o_in_ready = 1'b1;
                    n_state    = S_WAIT;
                end
            end
            default: begin
                n_state = S_WAIT;
            end
        endcase

        if (o_in_ready && i_in_valid) begin
            o_cmd.capture = 1'b1;
            n_state       = S_EXEC;
        end

        if (i_status.restart) begin
            n_state    = S_WAIT;
            n_phase    = PH_CONTROL;
            n_finished = 1'b0;
            n_has_pend = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_WAIT;
            r_phase    <= PH_CONTROL;
            r_finished <= 1'b0;
            r_has_pend <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_phase    <= n_phase;
            r_finished <= n_finished;
            r_has_pend <= n_has_pend;
        end
    end

    `BLZD_ASSERT_IMPLY(a_quiet_after_end, i_clk, i_rst_n, r_finished, o_cmd.push == blzd_pkg::OUT_NONE, "result issued after end of stream")
    `BLZD_ASSERT_NEXT(a_end_marks_finished, i_clk, i_rst_n, (o_cmd.push == blzd_pkg::OUT_DONE || o_cmd.push == blzd_pkg::OUT_ERR) && !i_status.restart, r_finished, "final result did not close the stream")

endmodule

// ===== sv/blzd_datapath.sv =====
// Decoder datapath: positions, flag shifter, history memory and result register.
`include "backward_lzss_decompressor_macros.svh"

module blzd_datapath #(
    parameter int WINDOW_DEPTH = blzd_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  blzd_pkg::t_dp_cmd                 i_cmd,
    output blzd_pkg::t_dp_status              o_status,
    input  logic [blzd_pkg::BYTE_W-1:0]       i_in_byte,
    input  logic                              i_cfg_we,
    input  logic [blzd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [blzd_pkg::POS_W-1:0]        i_cfg_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [blzd_pkg::BYTE_W-1:0]       o_out_byte,
    output logic [blzd_pkg::POS_W-1:0]        o_out_pos,
    output logic                              o_out_bvalid,
    output logic                              o_out_done,
    output logic                              o_out_err
);

    localparam int POS_W  = blzd_pkg::POS_W;
    localparam int BYTE_W = blzd_pkg::BYTE_W;
    localparam int LEN_W  = blzd_pkg::LEN_W;
    localparam int OFF_W  = blzd_pkg::OFF_W;
    localparam int FL_W   = blzd_pkg::FLAGS_LEFT_W;
    localparam int AW     = $clog2(WINDOW_DEPTH);

    // Control and stream state.
    logic [POS_W-1:0]  r_start, n_start;
    logic [POS_W-1:0]  r_stop, n_stop;
    logic [POS_W-1:0]  r_size, n_size;
    logic [POS_W-1:0]  r_wp, n_wp;
    logic [POS_W-1:0]  r_rp, n_rp;
    logic [BYTE_W-1:0] r_flags, n_flags;
    logic [FL_W-1:0]   r_fl, n_fl;
    logic [BYTE_W-1:0] r_pair_high, n_pair_high;
    logic [AW-1:0]     r_wr_addr, n_wr_addr;
    logic              r_out_valid, n_out_valid;

    // Payload registers.
    logic [BYTE_W-1:0] r_byte, n_byte;
    logic [LEN_W-1:0]  r_cnt, n_cnt;
    logic [AW-1:0]     r_rd_addr, n_rd_addr;
    logic [BYTE_W-1:0] r_pend_byte, n_pend_byte;
    logic [POS_W-1:0]  r_pend_pos, n_pend_pos;
    logic [BYTE_W-1:0] r_out_byte, n_out_byte;
    logic [POS_W-1:0]  r_out_pos, n_out_pos;
    logic              r_out_bvalid, n_out_bvalid;
    logic              r_out_done, n_out_done;
    logic              r_out_err, n_out_err;

    logic [BYTE_W-1:0] r_hist [WINDOW_DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    logic              w_restart;
    logic [LEN_W-1:0]  w_len;
    logic [OFF_W-1:0]  w_off;
    logic [POS_W-1:0]  w_wp_dec;
    logic [POS_W-1:0]  w_rp_dec;
    logic [POS_W:0]    w_ref_end;
    logic [AW-1:0]     w_wr_addr_dec;
    logic [AW-1:0]     w_rd_addr_dec;
    logic [AW:0]       w_rd_sum;
    logic [AW-1:0]     w_rd_init;
    logic              w_hist_we;
    logic [BYTE_W-1:0] w_hist_wdata;
    logic              w_out_free;

    always_comb begin
        unique case (i_cfg_idx)
            blzd_pkg::CFG_START, blzd_pkg::CFG_STOP, blzd_pkg::CFG_SIZE: begin
                w_restart = i_cfg_we;
            end
            default: begin
                w_restart = 1'b0;
            end
        endcase
    end

    assign w_len     = LEN_W'(r_pair_high[7:4]) + LEN_W'(blzd_pkg::LEN_BASE);
    assign w_off     = OFF_W'({r_pair_high[3:0], r_byte}) + OFF_W'(blzd_pkg::OFF_BASE);
    assign w_wp_dec  = r_wp - POS_W'(1);
    assign w_rp_dec  = r_rp - POS_W'(1);
    assign w_ref_end = {1'b0, r_wp} + (POS_W+1)'(w_off);

    // History is addressed relative to the stream start: the output size maps
    // to address zero and each written position steps one address down.
    assign w_wr_addr_dec = (r_wr_addr == '0) ? AW'(WINDOW_DEPTH - 1) : r_wr_addr - AW'(1);
    assign w_rd_addr_dec = (r_rd_addr == '0) ? AW'(WINDOW_DEPTH - 1) : r_rd_addr - AW'(1);
    assign w_rd_sum      = {1'b0, r_wr_addr} + (AW+1)'(w_off);
    assign w_rd_init     = (w_rd_sum >= (AW+1)'(WINDOW_DEPTH))
                         ? AW'(w_rd_sum - (AW+1)'(WINDOW_DEPTH)) : w_rd_sum[AW-1:0];

    assign w_hist_we    = i_cmd.op_lit || i_cmd.copy_wr;
    assign w_hist_wdata = i_cmd.op_lit ? r_byte : r_rdata;
    assign w_out_free   = !r_out_valid || i_out_ready;

    assign o_status.restart    = w_restart;
    assign o_status.out_free   = w_out_free;
    assign o_status.rp_le_stop = (r_rp <= r_stop);
    assign o_status.rp_lt2     = (r_rp < POS_W'(blzd_pkg::PAIR_MIN_POS));
    assign o_status.wp_zero    = (r_wp == '0);
    assign o_status.fl_zero    = (r_fl == '0);
    assign o_status.flag_msb   = r_flags[BYTE_W-1];
    assign o_status.low_fail   = (r_wp < POS_W'(w_len)) || (w_ref_end >= {1'b0, r_size});
    assign o_status.cnt_last   = (r_cnt == LEN_W'(1));

    always_comb begin
        n_start      = r_start;
        n_stop       = r_stop;
        n_size       = r_size;
        n_wp         = r_wp;
        n_rp         = r_rp;
        n_flags      = r_flags;
        n_fl         = r_fl;
        n_pair_high  = r_pair_high;
        n_wr_addr    = r_wr_addr;
        n_out_valid  = r_out_valid;
        n_byte       = r_byte;
        n_cnt        = r_cnt;
        n_rd_addr    = r_rd_addr;
        n_pend_byte  = r_pend_byte;
        n_pend_pos   = r_pend_pos;
        n_out_byte   = r_out_byte;
        n_out_pos    = r_out_pos;
        n_out_bvalid = r_out_bvalid;
        n_out_done   = r_out_done;
        n_out_err    = r_out_err;

        if (i_cmd.capture) begin
            n_byte = i_in_byte;
        end
        if (i_cmd.op_ctrl) begin
            n_rp    = w_rp_dec;
            n_flags = r_byte;
            n_fl    = FL_W'(blzd_pkg::FLAG_COUNT);
        end
        if (i_cmd.op_lit) begin
            n_rp        = w_rp_dec;
            n_wp        = w_wp_dec;
            n_wr_addr   = w_wr_addr_dec;
            n_pend_byte = r_byte;
            n_pend_pos  = w_wp_dec;
            n_flags     = {r_flags[BYTE_W-2:0], 1'b0};
            n_fl        = r_fl - FL_W'(1);
        end
        if (i_cmd.op_high) begin
            n_rp        = w_rp_dec;
            n_pair_high = r_byte;
        end
        if (i_cmd.op_low) begin
            n_rp      = w_rp_dec;
            n_cnt     = w_len;
            n_rd_addr = w_rd_init;
            n_flags   = {r_flags[BYTE_W-2:0], 1'b0};
            n_fl      = r_fl - FL_W'(1);
        end
        if (i_cmd.rd_issue) begin
            n_rd_addr = w_rd_addr_dec;
        end
        if (i_cmd.copy_wr) begin
            n_wp        = w_wp_dec;
            n_wr_addr   = w_wr_addr_dec;
            n_cnt       = r_cnt - LEN_W'(1);
            n_pend_byte = r_rdata;
            n_pend_pos  = w_wp_dec;
        end
        if (i_cmd.settle_clear) begin
            n_fl = '0;
        end

        case (i_cmd.push)
            blzd_pkg::OUT_COPY: begin
                n_out_valid  = 1'b1;
                n_out_byte   = r_rdata;
                n_out_pos    = w_wp_dec;
                n_out_bvalid = 1'b1;
                n_out_done   = 1'b0;
                n_out_err    = 1'b0;
            end
            blzd_pkg::OUT_PEND: begin
                n_out_valid  = 1'b1;
                n_out_byte   = r_pend_byte;
                n_out_pos    = r_pend_pos;
                n_out_bvalid = 1'b1;
                n_out_done   = i_cmd.push_done;
                n_out_err    = 1'b0;
            end
            blzd_pkg::OUT_DONE, blzd_pkg::OUT_ERR: begin
                n_out_valid  = 1'b1;
                n_out_byte   = '0;
                n_out_pos    = '0;
                n_out_bvalid = 1'b0;
                n_out_done   = 1'b1;
                n_out_err    = (i_cmd.push == blzd_pkg::OUT_ERR);
            end
            default: begin
                if (i_out_ready) begin
                    n_out_valid = 1'b0;
                end
            end
        endcase

        // A register write restarts the stream with the new settings.
        if (w_restart) begin
            unique case (i_cfg_idx)
                blzd_pkg::CFG_START: n_start = i_cfg_data;
                blzd_pkg::CFG_STOP:  n_stop  = i_cfg_data;
                default:             n_size  = i_cfg_data;
            endcase
            n_wp        = (i_cfg_idx == blzd_pkg::CFG_SIZE) ? i_cfg_data : r_size;
            n_rp        = (i_cfg_idx == blzd_pkg::CFG_START) ? i_cfg_data : r_start;
            n_flags     = '0;
            n_fl        = '0;
            n_pair_high = '0;
            n_wr_addr   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start     <= '0;
            r_stop      <= '0;
            r_size      <= '0;
            r_wp        <= '0;
            r_rp        <= '0;
            r_flags     <= '0;
            r_fl        <= '0;
            r_pair_high <= '0;
            r_wr_addr   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_start     <= n_start;
            r_stop      <= n_stop;
            r_size      <= n_size;
            r_wp        <= n_wp;
            r_rp        <= n_rp;
            r_flags     <= n_flags;
            r_fl        <= n_fl;
            r_pair_high <= n_pair_high;
            r_wr_addr   <= n_wr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte       <= n_byte;
        r_cnt        <= n_cnt;
        r_rd_addr    <= n_rd_addr;
        r_pend_byte  <= n_pend_byte;
        r_pend_pos   <= n_pend_pos;
        r_out_byte   <= n_out_byte;
        r_out_pos    <= n_out_pos;
        r_out_bvalid <= n_out_bvalid;
        r_out_done   <= n_out_done;
        r_out_err    <= n_out_err;
    end

    always_ff @(posedge i_clk) begin
        if (w_hist_we) begin
            r_hist[w_wr_addr_dec] <= w_hist_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_issue) begin
            r_rdata <= r_hist[r_rd_addr];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_out_pos    = r_out_pos;
    assign o_out_bvalid = r_out_bvalid;
    assign o_out_done   = r_out_done;
    assign o_out_err    = r_out_err;

    `BLZD_ASSERT_IMPLY(a_push_into_free, i_clk, i_rst_n, i_cmd.push != blzd_pkg::OUT_NONE, w_out_free, "result loaded over an untaken one")
    `BLZD_ASSERT_IMPLY(a_hist_ports_apart, i_clk, i_rst_n, i_cmd.rd_issue && w_hist_we, r_rd_addr != w_wr_addr_dec, "history read and write hit one address")
    `BLZD_ASSERT_IMPLY(a_copy_count_live, i_clk, i_rst_n, i_cmd.copy_wr, r_cnt != '0, "copy step with no bytes left")

endmodule

// ===== tb/blzd_decode_checker.sv =====
`timescale 1ns / 100ps
// Decoder model and result checker for the backward LZSS decompressor testbench.
module blzd_decode_checker
    import blzd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic [BYTE_W-1:0]    i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic [TDATA_W-1:0]   i_out_data,
    input  logic [TUSER_W-1:0]   i_out_user,
    input  logic                 i_out_last,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [POS_W-1:0]     i_cfg_data,
    output int                   o_mismatches,
    output int                   o_outstanding
);

    localparam int HIST_AW = $clog2(WINDOW_DEPTH_DEF);

    typedef enum logic [1:0] {
        EXPECT_CONTROL,
        EXPECT_LITERAL,
        EXPECT_PAIR_HIGH,
        EXPECT_PAIR_LOW
    } t_decode_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [POS_W-1:0]  pos;
        logic              valid;
        logic              last;
        logic              err;
    } t_decoded;

    logic [POS_W-1:0]  reg_start;
    logic [POS_W-1:0]  reg_stop;
    logic [POS_W-1:0]  reg_size;
    logic [BYTE_W-1:0] history [WINDOW_DEPTH_DEF];
    logic [POS_W-1:0]  wr_pos;
    logic [POS_W-1:0]  rd_pos;
    logic [BYTE_W-1:0] flags;
    int unsigned       flags_left;
    logic [BYTE_W-1:0] pair_hi;
    t_decode_phase     phase;
    logic              stream_over;
    t_decoded          decoded_fifo [$];

    task automatic report_mismatch(input string what);
        if (o_mismatches < 100) begin
            $display("[%0t] decompressor mismatch: %s", $time, what);
        end
        o_mismatches++;
    endtask

    function automatic void restart_stream();
        wr_pos      = reg_size;
        rd_pos      = reg_start;
        flags       = '0;
        flags_left  = 0;
        pair_hi     = '0;
        phase       = EXPECT_CONTROL;
        stream_over = 1'b0;
    endfunction

    function automatic void emit(input logic [BYTE_W-1:0] data, input logic [POS_W-1:0] pos,
                                 input logic valid, input logic last, input logic err);
        decoded_fifo.push_back(t_decoded'{data, pos, valid, last, err});
    endfunction

    function automatic void next_flag();
        flags      = flags << 1;
        flags_left = flags_left - 1;
    endfunction

    // Chooses what the next byte means; returns 1 when the stream has ended.
    function automatic logic stream_ends();
        if (flags_left != 0 && rd_pos > reg_stop && wr_pos != 0) begin
            phase = flags[7] ? EXPECT_PAIR_HIGH : EXPECT_LITERAL;
            return 1'b0;
        end
        flags_left = 0;
        phase      = EXPECT_CONTROL;
        if (rd_pos > reg_stop) begin
            return 1'b0;
        end
        stream_over = 1'b1;
        return 1'b1;
    endfunction

    task automatic decode_byte(input logic [BYTE_W-1:0] b);
        int unsigned       n_new;
        int unsigned       len;
        int unsigned       ref_off;
        logic [BYTE_W-1:0] d;
        n_new = 0;
        if (stream_over) begin
            return;
        end
        case (phase)
            EXPECT_CONTROL: begin
                if (rd_pos <= reg_stop) begin
                    stream_over = 1'b1;
                    emit('0, '0, 1'b0, 1'b1, 1'b0);
                    return;
                end
                rd_pos     = rd_pos - 1'b1;
                flags      = b;
                flags_left = FLAG_COUNT;
            end
            EXPECT_LITERAL: begin
                rd_pos = rd_pos - 1'b1;
                wr_pos = wr_pos - 1'b1;
                history[HIST_AW'(wr_pos % WINDOW_DEPTH_DEF)] = b;
                emit(b, wr_pos, 1'b1, 1'b0, 1'b0);
                n_new = 1;
                next_flag();
            end
            EXPECT_PAIR_HIGH: begin
                // Too little input left for a pair: the byte is dropped and the stream fails.
                if (rd_pos < PAIR_MIN_POS) begin
                    stream_over = 1'b1;
                    emit('0, '0, 1'b0, 1'b1, 1'b1);
                    return;
                end
                rd_pos  = rd_pos - 1'b1;
                pair_hi = b;
                phase   = EXPECT_PAIR_LOW;
                return;
            end
            default: begin
                rd_pos  = rd_pos - 1'b1;
                len     = pair_hi[7:4] + LEN_BASE;
                ref_off = {pair_hi[3:0], b} + OFF_BASE;
                if (wr_pos < len || wr_pos + ref_off >= reg_size) begin
                    stream_over = 1'b1;
                    emit('0, '0, 1'b0, 1'b1, 1'b1);
                    return;
                end
                for (int j = 0; j < len; j++) begin
                    d      = history[HIST_AW'((wr_pos + ref_off) % WINDOW_DEPTH_DEF)];
                    wr_pos = wr_pos - 1'b1;
                    history[HIST_AW'(wr_pos % WINDOW_DEPTH_DEF)] = d;
                    emit(d, wr_pos, 1'b1, 1'b0, 1'b0);
                    n_new++;
                end
                next_flag();
            end
        endcase
        if (stream_ends()) begin
            if (n_new != 0) begin
                decoded_fifo[decoded_fifo.size()-1].last = 1'b1;
            end else begin
                emit('0, '0, 1'b0, 1'b1, 1'b0);
            end
        end
    endtask

    task automatic check_result();
        t_decoded want;
        if (decoded_fifo.size() == 0) begin
            report_mismatch($sformatf("unexpected result byte %02h pos %06h user %b last %b",
                            i_out_data[7:0], i_out_data[31:8], i_out_user, i_out_last));
        end else begin
            want = decoded_fifo.pop_front();
            if (i_out_data[7:0] !== want.data || i_out_data[31:8] !== want.pos
                    || i_out_user[0] !== want.valid || i_out_last !== want.last
                    || i_out_user[1] !== want.err) begin
                report_mismatch($sformatf(
                    "got byte %02h pos %06h valid %b last %b err %b, want %02h %06h %b %b %b",
                    i_out_data[7:0], i_out_data[31:8], i_out_user[0], i_out_last,
                    i_out_user[1], want.data, want.pos, want.valid, want.last, want.err));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reg_start = '0;
            reg_stop  = '0;
            reg_size  = '0;
            restart_stream();
            decoded_fifo.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                check_result();
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_START: begin
                        reg_start = i_cfg_data;
                        restart_stream();
                    end
                    CFG_STOP: begin
                        reg_stop = i_cfg_data;
                        restart_stream();
                    end
                    CFG_SIZE: begin
                        reg_size = i_cfg_data;
                        restart_stream();
                    end
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                decode_byte(i_in_data);
            end
        end
        o_outstanding <= decoded_fifo.size();
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Top of the decompressor testbench: clock, reset, stream stimulus and the verdict.
module testbench;
    import blzd_pkg::*;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic [BYTE_W-1:0]    s_axis_tdata  = '0;
    logic                 s_axis_tready;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]   m_axis_tdata;
    logic [TUSER_W-1:0]   m_axis_tuser;
    logic                 m_axis_tlast;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx     = CFG_START;
    logic [POS_W-1:0]     i_cfg_data    = '0;

    int                   mismatches;
    int                   outstanding;

    logic [BYTE_W-1:0]    stream_q [$];   // compressed bytes in the order they are sent
    int unsigned          bytes_out;      // bytes the composed stream decodes to
    int unsigned          burst_left    = 0;
    int unsigned          random_items;
    int unsigned          budget;
    int unsigned          stream_no;

    // Receiver: stall pattern of its own, plus a long hold-off on request.
    logic                 hold_req      = 1'b0;
    logic                 hold_ack      = 1'b0;
    int unsigned          rx_hold_left  = 0;
    int unsigned          rx_phase_left = 0;
    int unsigned          rx_stall_pct  = 0;

    always #6 i_clk = ~i_clk;

    backward_lzss_decompressor u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    blzd_decode_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_axis_tvalid),
        .i_in_ready    (s_axis_tready),
        .i_in_data     (s_axis_tdata),
        .i_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .i_out_data    (m_axis_tdata),
        .i_out_user    (m_axis_tuser),
        .i_out_last    (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always @(posedge i_clk) begin
        if (rx_hold_left != 0) begin
            rx_hold_left  <= rx_hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_req != hold_ack) begin
            hold_ack      <= hold_req;
            rx_hold_left  <= 400;
            m_axis_tready <= 1'b0;
        end else begin
            if (rx_phase_left == 0) begin
                rx_phase_left <= $urandom_range(16, 250);
                case ($urandom_range(0, 4))
                    0, 1:    rx_stall_pct <= 0;
                    2:       rx_stall_pct <= 25;
                    3:       rx_stall_pct <= 60;
                    default: rx_stall_pct <= 90;
                endcase
            end else begin
                rx_phase_left <= rx_phase_left - 1;
            end
            m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    task automatic program_stream(input logic [POS_W-1:0] start_v, input logic [POS_W-1:0] stop_v,
                                  input logic [POS_W-1:0] size_v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_START;
        i_cfg_data <= start_v;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_STOP;
        i_cfg_data <= stop_v;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_SIZE;
        i_cfg_data <= size_v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // One transfer on the input side; bursts end in a random gap.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = $urandom_range(1, 24);
        end else begin
            burst_left--;
        end
    endtask

    // Waits for every predicted result, then lets a copy in flight run out.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic run_stream(input logic [POS_W-1:0] start_v, input logic [POS_W-1:0] stop_v,
                              input logic [POS_W-1:0] size_v, input int unsigned n_extra,
                              input bit hold_off);
        program_stream(start_v, stop_v, size_v);
        if (hold_off) begin
            hold_req <= ~hold_req;
        end
        foreach (stream_q[i]) begin
            send_byte(stream_q[i]);
        end
        repeat (n_extra) send_byte(BYTE_W'($urandom));
        wait_idle();
    endtask

    // Builds a well-formed stream of n_items tokens; with bad_offset one pair
    // reaches past the bytes already decoded.
    task automatic compose_stream(input int unsigned n_items, input bit bad_offset);
        int unsigned       k;
        int unsigned       bad_at;
        int unsigned       ctrl_at;
        logic [BYTE_W-1:0] ctrl;
        logic [3:0]        len_code;
        logic [11:0]       span;
        bit                make_pair;
        stream_q.delete();
        bytes_out = 0;
        k         = 0;
        bad_at    = bad_offset ? $urandom_range(0, n_items - 1) : n_items;
        while (k < n_items) begin
            ctrl    = BYTE_W'($urandom);
            ctrl_at = stream_q.size();
            stream_q.push_back('0);
            for (int i = 7; i >= 0 && k < n_items; i--) begin
                make_pair = (k == bad_at) || (bytes_out >= 3 && $urandom_range(0, 99) < 45);
                ctrl[i]   = make_pair;
                if (make_pair) begin
                    len_code = 4'($urandom);
                    if (k == bad_at) begin
                        span = 12'($urandom_range((bytes_out >= 2) ? bytes_out - 2 : 0, 4095));
                    end else begin
                        span = 12'($urandom_range(0, bytes_out - 3));
                    end
                    stream_q.push_back({len_code, span[11:8]});
                    stream_q.push_back(span[7:0]);
                    bytes_out += len_code + 3;
                end else begin
                    stream_q.push_back(BYTE_W'($urandom));
                    bytes_out++;
                end
                k++;
            end
            stream_q[ctrl_at] = ctrl;
        end
    endtask

    task automatic run_random_stream(input bit hold_off, output int unsigned n_budget);
        int unsigned      kind;
        int unsigned      cut;
        int unsigned      n_extra;
        logic [POS_W-1:0] size_v;
        logic [POS_W-1:0] stop_v;
        kind    = $urandom_range(0, 99);
        n_extra = $urandom_range(0, 2);
        if (kind < 15) begin
            // Noise: random bytes under random settings.
            stream_q.delete();
            repeat ($urandom_range(4, 40)) stream_q.push_back(BYTE_W'($urandom));
            case ($urandom_range(0, 2))
                0:       size_v = '0;
                1:       size_v = POS_W'($urandom_range(1, 80));
                default: size_v = POS_W'($urandom_range(0, 24'hFFFFFF));
            endcase
            n_extra = $urandom_range(1, 3);
        end else begin
            compose_stream($urandom_range(3, 18), kind < 27);
            if (kind >= 27 && kind < 37) begin
                size_v = POS_W'($urandom_range(0, bytes_out - 1));
            end else if (kind >= 37 && kind < 47) begin
                size_v = POS_W'(bytes_out + $urandom_range(1, 1000));
            end else if (kind >= 47 && kind < 52) begin
                size_v = 24'hFFFFFF;
            end else begin
                size_v = POS_W'(bytes_out);
            end
        end
        cut = 0;
        if ($urandom_range(0, 9) == 0 && stream_q.size() > 2) begin
            cut = $urandom_range(1, 2);
        end
        n_budget = stream_q.size() - cut;
        case ($urandom_range(0, 9))
            0:       stop_v = '0;
            1:       stop_v = POS_W'(24'hFFFFFF - n_budget);
            default: stop_v = POS_W'($urandom_range(0, 24'hFFFFFF - n_budget));
        endcase
        run_stream(POS_W'(stop_v + n_budget), stop_v, size_v, n_extra, hold_off);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Straight after reset the stream is already over: one done result, then nothing.
        send_byte(8'hC3);
        send_byte(8'h3C);
        wait_idle();

        // Empty stream, start below stop.
        stream_q = '{8'h77};
        run_stream(24'h000000, 24'hFFFFFF, 24'h000000, 0, 1'b0);

        // Literals of both extremes, longest and shortest copies, output filled exactly.
        stream_q = '{8'h18, 8'h00, 8'hFF, 8'h5A, 8'hF0, 8'h00, 8'h00, 8'h02};
        run_stream(24'hFFFFFF, 24'hFFFFF7, 24'd24, 0, 1'b0);

        // Output full: the rest of the input is taken as control bytes.
        stream_q = '{8'h00, 8'h11, 8'hEE, 8'h33, 8'hCC, 8'h81};
        run_stream(24'd6, 24'd0, 24'd2, 0, 1'b0);

        // Pair with too little input left.
        stream_q = '{8'h80, 8'h5A};
        run_stream(24'd2, 24'd0, 24'd5, 0, 1'b0);

        // Copy longer than the space left in the output.
        stream_q = '{8'h20, 8'hA5, 8'h5A, 8'h00, 8'h00};
        run_stream(24'd6, 24'd1, 24'd4, 0, 1'b0);

        // Reference beyond the end of the buffer, largest offset and length.
        stream_q = '{8'h40, 8'h3C, 8'hFF, 8'hFF};
        run_stream(24'h000104, 24'h000100, 24'hFFFFFF, 0, 1'b0);

        random_items = 0;
        stream_no    = 0;
        while (random_items < 280) begin
            run_random_stream(stream_no == 1, budget);
            random_items += budget;
            stream_no++;
        end

        if (mismatches == 0 && outstanding == 0) begin
            $display("PASS backward_lzss_decompressor");
        end else begin
            $display("FAIL backward_lzss_decompressor");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("FAIL backward_lzss_decompressor");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/blzd_pkg.sv
sv/blzd_ctrl.sv
sv/blzd_datapath.sv
sv/backward_lzss_decompressor.sv
tb/blzd_decode_checker.sv
tb/testbench.sv
